// ===== rtl/agwm_pkg.sv =====
// Shared types and constants for the arrival gap window mean block.
// No dependencies; every other file in rtl/ except agwm_ram imports this package.
package agwm_pkg;

  localparam int STAMP_W     = 64;
  localparam int GAP_W       = 32;
  localparam int FILL_W      = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [GAP_W-1:0] GAP_FIRST = GAP_W'(1);
  localparam logic [GAP_W-1:0] GAP_MAX   = {GAP_W{1'b1}};

  // One classified arrival handed from the front end to the back end.
  typedef struct packed {
    logic [GAP_W-1:0] gap;
    logic             err;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_UPDATE,
    BK_DIVIDE
  } back_state_t;

endpackage

// ===== rtl/agwm_if.sv =====
// Valid/ready channel interfaces for arrival words and result words.
// Depends on agwm_pkg for field widths.
interface agwm_in_if import agwm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAMP_W-1:0] arrival_stamp;

  modport source (output valid, output arrival_stamp, input ready);
  modport sink (input valid, input arrival_stamp, output ready);
endinterface

interface agwm_out_if import agwm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GAP_W-1:0]  mean_gap;
  logic [FILL_W-1:0] window_fill;
  logic              stamp_error;

  modport source (output valid, output mean_gap, output window_fill, output stamp_error,
                  input ready);
  modport sink (input valid, input mean_gap, input window_fill, input stamp_error,
                output ready);
endinterface

// ===== rtl/agwm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module agwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/agwm_front.sv =====
// Front end: takes arrival words, forms the saturated gap and flags stale stamps.
// Depends on agwm_pkg and agwm_in_if.
module agwm_front import agwm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  agwm_in_if.sink         in_word,
  output logic            push_valid,
  output job_t            push_job,
  input  logic            push_ready
);

  logic [STAMP_W-1:0] prev_stamp_r, prev_stamp_nxt;
  logic [STAMP_W:0]   diff;
  logic               first;
  logic               stale;
  logic               accept;

  // Borrow out of the subtract doubles as the "less than" compare.
  assign diff   = {1'b0, in_word.arrival_stamp} - {1'b0, prev_stamp_r};
  assign first  = (prev_stamp_r == '0);
  assign stale  = !first && (diff[STAMP_W] || (diff[STAMP_W-1:0] == '0));
  assign accept = in_word.valid && push_ready;

  assign in_word.ready = push_ready;
  assign push_valid    = in_word.valid;

  always_comb begin
    push_job.err = stale;
    if (first) begin
      push_job.gap = GAP_FIRST;
    end else if (diff[STAMP_W-1:GAP_W] != '0) begin
      push_job.gap = GAP_MAX;
    end else begin
      push_job.gap = diff[GAP_W-1:0];
    end
  end

  always_comb begin
    prev_stamp_nxt = prev_stamp_r;
    if (accept && !stale) begin
      prev_stamp_nxt = in_word.arrival_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_stamp_r <= '0;
    end else begin
      prev_stamp_r <= prev_stamp_nxt;
    end
  end

endmodule

// ===== rtl/agwm_queue.sv =====
// Short FIFO of classified jobs between the front end and the back end.
// Depends on agwm_pkg.
module agwm_queue import agwm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  job_t push_job,
  output logic push_ready,
  output logic pop_valid,
  output job_t pop_job,
  input  logic pop_ready
);

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/agwm_back.sv =====
// Back end: gap ring update, exact window sum, bit-serial mean divide, result word.
// Depends on agwm_pkg, agwm_out_if and agwm_ram.
module agwm_back import agwm_pkg::*; #(
  parameter int WINDOW = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  input  job_t      pop_job,
  output logic      pop_ready,
  agwm_out_if.source out_word
);

  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int PTR_W  = $clog2(WINDOW);
  localparam int SUM_W  = GAP_W + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);

  back_state_t       state_r, state_nxt;
  logic [GAP_W-1:0]  gap_r, gap_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [GAP_W-1:0]  mean_r, mean_nxt;
  logic [SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [GAP_W-1:0]  out_mean_r, out_mean_nxt;
  logic [FILL_W-1:0] out_fill_r, out_fill_nxt;
  logic              out_err_r, out_err_nxt;

  logic              full;
  logic              pop_fire;
  logic              ram_wr_en;
  logic [PTR_W-1:0]  ram_wr_addr;
  logic [GAP_W-1:0]  old_gap;
  logic [GAP_W-1:0]  evicted;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    trial_diff;
  logic              trial_ge;

  assign full      = (held_r == CNT_W'(WINDOW));
  assign pop_ready = (state_r == BK_IDLE) && !out_valid_r;
  assign pop_fire  = pop_valid && pop_ready;
  assign evicted   = full ? old_gap : '0;

  // One quotient bit per cycle: restoring divide of the sum by the fill count.
  assign trial      = {rem_r, dvd_r[SUM_W-1]};
  assign trial_diff = trial - {1'b0, held_r};
  assign trial_ge   = !trial_diff[CNT_W];

  agwm_ram #(
    .WIDTH (GAP_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (gap_r),
    .rd_en   (pop_fire),
    .rd_addr (ptr_r),
    .rd_data (old_gap)
  );

  always_comb begin
    state_nxt     = state_r;
    gap_nxt       = gap_r;
    held_nxt      = held_r;
    ptr_nxt       = ptr_r;
    sum_nxt       = sum_r;
    mean_nxt      = mean_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_word.ready;
    out_mean_nxt  = out_mean_r;
    out_fill_nxt  = out_fill_r;
    out_err_nxt   = out_err_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = full ? ptr_r : held_r[PTR_W-1:0];

    case (state_r)
      BK_IDLE: begin
        if (pop_fire) begin
          if (pop_job.err) begin
            out_valid_nxt = 1'b1;
            out_mean_nxt  = mean_r;
            out_fill_nxt  = FILL_W'(held_r);
            out_err_nxt   = 1'b1;
          end else begin
            gap_nxt   = pop_job.gap;
            state_nxt = BK_UPDATE;
          end
        end
      end
      BK_UPDATE: begin
        ram_wr_en = 1'b1;
        sum_nxt   = sum_r - SUM_W'(evicted) + SUM_W'(gap_r);
        if (full) begin
          ptr_nxt = (ptr_r == PTR_W'(WINDOW - 1)) ? '0 : ptr_r + 1'b1;
        end else begin
          held_nxt = held_r + 1'b1;
        end
        dvd_nxt   = sum_nxt;
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = BK_DIVIDE;
      end
      BK_DIVIDE: begin
        rem_nxt  = trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
        dvd_nxt  = {dvd_r[SUM_W-2:0], trial_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          mean_nxt      = dvd_nxt[GAP_W-1:0];
          out_valid_nxt = 1'b1;
          out_mean_nxt  = dvd_nxt[GAP_W-1:0];
          out_fill_nxt  = FILL_W'(held_r);
          out_err_nxt   = 1'b0;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign out_word.valid       = out_valid_r;
  assign out_word.mean_gap    = out_mean_r;
  assign out_word.window_fill = out_fill_r;
  assign out_word.stamp_error = out_err_r;

  always_ff @(posedge clk) begin
    gap_r      <= gap_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    out_mean_r <= out_mean_nxt;
    out_fill_r <= out_fill_nxt;
    out_err_r  <= out_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      held_r      <= '0;
      ptr_r       <= '0;
      sum_r       <= '0;
      mean_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      ptr_r       <= ptr_nxt;
      sum_r       <= sum_nxt;
      mean_r      <= mean_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/arrival_gap_window_mean.sv =====
// Top level of the arrival gap window mean block.
// Depends on agwm_pkg, agwm_if, agwm_front, agwm_queue and agwm_back.
// Usage:
//   in_word carries one arrival stamp per word; out_word returns one result
//   word per arrival: the floor mean of the last WINDOW gaps, the number of
//   gaps held, and a stale-stamp flag. A stale stamp (not above the last good
//   one) changes no state and reports the current mean with the flag set.
// Sequence and throughput:
//   The front end classifies and queues a word in the cycle it is accepted.
//   The back end pops it from the queue while reading the ring, updates
//   the sum in BK_UPDATE and runs its bit-serial divider in BK_DIVIDE; the
//   result register then loads the word. The back end takes no new word
//   until it is idle and its result word has been taken.
//   A stale word skips the divider: the result register loads it on the pop.
// Reset:
//   rst_n (synchronous, active low) clears the last stamp, fill count, ring
//   pointer, sum and mean; the ring is not cleared, only written entries are used.
// Stalls:
//   The result register holds its word until out_word.ready; meanwhile the
//   front end keeps accepting into the two-entry queue, then drops ready.
module arrival_gap_window_mean import agwm_pkg::*; #(
  parameter int WINDOW = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  agwm_in_if.sink    in_word,
  agwm_out_if.source out_word
);

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  job_t push_job, pop_job;

  // Classify arrivals and advance the last good stamp.
  agwm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  // Decouple the fast front end from the long back-end divide.
  agwm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop_ready  (pop_ready)
  );

  // Update the window and compute the mean, in arrival order.
  agwm_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .pop_ready (pop_ready),
    .out_word  (out_word)
  );

endmodule
